### rtl/core/ptd_pkg.sv
// shared types and constants of the periodic task dispatcher
`default_nettype none

package ptd_pkg;

	localparam int unsigned MAX_TASKS_DEFAULT = 16;

	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned INDEX_W  = 4;
	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned SLOT_W   = 4;

	// period in ms is 1000 / freq_hz, at most 1000
	localparam int unsigned PERIOD_W      = 10;
	localparam int unsigned MS_PER_SECOND = 1000;
	localparam int unsigned DIV_CNT_W     = $clog2(PERIOD_W);

	// at most this many due slots are reported per tick
	localparam int unsigned RES_LIMIT = 16;
	localparam int unsigned RES_CNT_W = $clog2(RES_LIMIT + 1);

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK     = 3'd0,
		OP_CREATE   = 3'd1,
		OP_START    = 3'd2,
		OP_STOP     = 3'd3,
		OP_SET_FREQ = 3'd4
	} opcode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DUE     = 2'd0,
		KIND_CREATED = 2'd1,
		KIND_FULL    = 2'd2
	} kind_t;

	typedef struct packed {
		logic                started;
		logic [PERIOD_W-1:0] period;
		logic [TIME_W-1:0]   last_run;
	} entry_t;

endpackage

`default_nettype wire

### rtl/core/periodic_task_dispatcher.sv
// periodic task dispatcher: task table in one memory, sequential scan and period divider
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------------------------
//   request | req_valid | req_stall | opcode, task_index, freq_hz, start_now, now_ms
//   result  | res_valid | res_stall | kind, slot, last
//
// tick: one table entry read per cycle from the single read port, while a stalled result does not hold the scan.
// create and set frequency: the period divider makes one quotient bit a cycle.
// start and stop: read, modify, write back. table full: a full result only, no table write.
// reset clears the task count and control registers, not the table; every entry is written by create before it is read.
// a stalled result holds the scan once a further due slot is found; one more due result waits in a pending register.
`default_nettype none

module periodic_task_dispatcher #(
	parameter int unsigned MAX_TASKS = ptd_pkg::MAX_TASKS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output      logic                          req_stall,
	input  wire logic [ptd_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic [ptd_pkg::INDEX_W-1:0]   task_index,
	input  wire logic [ptd_pkg::FREQ_W-1:0]    freq_hz,
	input  wire logic                          start_now,
	input  wire logic [ptd_pkg::TIME_W-1:0]    now_ms,
	output      logic                          res_valid,
	input  wire logic                          res_stall,
	output      logic [ptd_pkg::KIND_W-1:0]    kind,
	output      logic [ptd_pkg::SLOT_W-1:0]    slot,
	output      logic                          last
);

	import ptd_pkg::*;

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
	localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_CWRITE,
		S_FULL,
		S_MREAD,
		S_MWRITE,
		S_TEVAL,
		S_TFIN
	} state_t;

	state_t state_q, state_n;

	// task table
	entry_t mem [MAX_TASKS];
	entry_t rd_data_q;
	logic   we, re;
	logic [IDX_W-1:0] waddr, raddr;
	entry_t wdata;

	// request registers
	logic [OPCODE_W-1:0] op_q;
	logic [IDX_W-1:0]    idx_q;
	logic [FREQ_W-1:0]   freq_q;
	logic                start_q;
	logic [TIME_W-1:0]   now_q;

	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     scan_idx_q;
	logic [RES_CNT_W-1:0] res_n_q;
	logic                 pend_v_q;
	logic [SLOT_W-1:0]    pend_slot_q;

	// period divider: remainder, dividend shifting out while quotient shifts in
	logic [FREQ_W-1:0]    rem_q;
	logic [PERIOD_W-1:0]  div_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [FREQ_W:0]      trial;
	logic                 trial_ge;
	logic [PERIOD_W-1:0]  period_n;

	logic                  out_v_q;
	logic [KIND_W-1:0]     kind_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  last_q;
	logic                  out_free;
	logic                  out_load;
	logic [KIND_W-1:0]     out_kind_n;
	logic [SLOT_W-1:0]     out_slot_n;
	logic                  out_last_n;

	logic accept;
	logic idx_ok;
	logic full;
	logic [TIME_W-1:0] diff;
	logic due, rep, hold, last_slot;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign res_valid = out_v_q;
	assign kind      = kind_q;
	assign slot      = slot_q;
	assign last      = last_q;
	assign out_free  = !out_v_q || !res_stall;

	assign idx_ok = CMP_W'(task_index) < CMP_W'(count_q);
	assign full   = (count_q == CNT_W'(MAX_TASKS));

	assign trial    = {rem_q, div_q[PERIOD_W-1]};
	assign trial_ge = trial >= {1'b0, freq_q};
	assign period_n = (freq_q == '0) ? '0 : div_q;

	assign diff      = now_q - rd_data_q.last_run;
	assign due       = rd_data_q.started && (diff >= TIME_W'(rd_data_q.period));
	assign rep       = res_n_q < RES_CNT_W'(RES_LIMIT);
	assign hold      = due && rep && pend_v_q && !out_free;
	assign last_slot = (CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q;

	always_comb begin
		state_n    = state_q;
		we         = 1'b0;
		waddr      = idx_q;
		wdata      = rd_data_q;
		re         = 1'b0;
		raddr      = scan_idx_q + IDX_W'(1);
		out_load   = 1'b0;
		out_kind_n = KIND_DUE;
		out_slot_n = pend_slot_q;
		out_last_n = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_TICK: begin
							if (count_q != '0) begin
								re      = 1'b1;
								raddr   = '0;
								state_n = S_TEVAL;
							end
						end
						OP_CREATE: begin
							state_n = full ? S_FULL : S_DIV;
						end
						OP_START, OP_STOP: begin
							if (idx_ok) begin
								re      = 1'b1;
								raddr   = IDX_W'(task_index);
								state_n = S_MWRITE;
							end
						end
						OP_SET_FREQ: begin
							if (idx_ok) begin
								state_n = S_DIV;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(PERIOD_W - 1)) begin
					state_n = (op_q == OP_CREATE) ? S_CWRITE : S_MREAD;
				end
			end
			S_CWRITE: begin
				if (out_free) begin
					we               = 1'b1;
					waddr            = IDX_W'(count_q);
					wdata.started    = start_q;
					wdata.period     = period_n;
					wdata.last_run   = '0;
					out_load         = 1'b1;
					out_kind_n       = KIND_CREATED;
					out_slot_n       = SLOT_W'(count_q);
					out_last_n       = 1'b1;
					state_n          = S_IDLE;
				end
			end
			S_FULL: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_n = KIND_FULL;
					out_slot_n = '0;
					out_last_n = 1'b1;
					state_n    = S_IDLE;
				end
			end
			S_MREAD: begin
				re      = 1'b1;
				raddr   = idx_q;
				state_n = S_MWRITE;
			end
			S_MWRITE: begin
				we = 1'b1;
				case (op_q)
					OP_START:    wdata.started = 1'b1;
					OP_STOP:     wdata.started = 1'b0;
					OP_SET_FREQ: wdata.period  = period_n;
					default: begin
					end
				endcase
				state_n = S_IDLE;
			end
			S_TEVAL: begin
				if (!hold) begin
					if (due) begin
						we             = 1'b1;
						waddr          = scan_idx_q;
						wdata.last_run = now_q;
						// a newer due slot pushes the pending one out, not last
						if (rep && pend_v_q) begin
							out_load = 1'b1;
						end
					end
					if (last_slot) begin
						state_n = S_TFIN;
					end else begin
						re = 1'b1;
					end
				end
			end
			S_TFIN: begin
				if (!pend_v_q) begin
					state_n = S_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last_n = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			res_n_q     <= '0;
			pend_v_q    <= 1'b0;
			pend_slot_q <= '0;
			out_v_q     <= 1'b0;
			kind_q      <= '0;
			slot_q      <= '0;
			last_q      <= 1'b0;
			op_q        <= '0;
			idx_q       <= '0;
			freq_q      <= '0;
			start_q     <= 1'b0;
			now_q       <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_n;

			if (out_load) begin
				out_v_q <= 1'b1;
				kind_q  <= out_kind_n;
				slot_q  <= out_slot_n;
				last_q  <= out_last_n;
			end else if (!res_stall) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= opcode;
						idx_q      <= IDX_W'(task_index);
						freq_q     <= freq_hz;
						start_q    <= start_now;
						now_q      <= now_ms;
						scan_idx_q <= '0;
						res_n_q    <= '0;
						pend_v_q   <= 1'b0;
						rem_q      <= '0;
						div_q      <= PERIOD_W'(MS_PER_SECOND);
						div_cnt_q  <= '0;
					end
				end
				S_DIV: begin
					div_q     <= {div_q[PERIOD_W-2:0], trial_ge};
					rem_q     <= trial_ge ? FREQ_W'(trial - {1'b0, freq_q}) : FREQ_W'(trial);
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				end
				S_CWRITE: begin
					if (out_free) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_TEVAL: begin
					if (!hold) begin
						if (due && rep) begin
							pend_v_q    <= 1'b1;
							pend_slot_q <= SLOT_W'(scan_idx_q);
							res_n_q     <= res_n_q + RES_CNT_W'(1);
						end
						if (!last_slot) begin
							scan_idx_q <= scan_idx_q + IDX_W'(1);
						end
					end
				end
				S_TFIN: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the periodic task dispatcher
`timescale 1ns / 1ps

module testbench;
	import ptd_pkg::*;

	localparam int unsigned TASKS        = MAX_TASKS_DEFAULT;
	localparam int unsigned RANDOM_ITEMS = 265;
	localparam int unsigned PRESSURE_AT  = 120;
	localparam int unsigned QUIET_FROM   = 230;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [INDEX_W-1:0]  idx;
		logic [FREQ_W-1:0]   freq;
		logic                start;
		logic [TIME_W-1:0]   now;
	} request_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic                last;
	} outcome_t;

	typedef struct packed {
		request_t            req;
		logic [4:0]          reps;
		logic                typed;
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [INDEX_W-1:0]  task_index = '0;
	logic [FREQ_W-1:0]   freq_hz = '0;
	logic                start_now = 1'b0;
	logic [TIME_W-1:0]   now_ms = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   slot;
	logic                last;

	// shadow of the task table
	logic [PERIOD_W-1:0] period_mem [TASKS];
	logic [TIME_W-1:0]   last_run_mem [TASKS];
	logic                started_mem [TASKS];
	int unsigned         created = 0;

	outcome_t            step_out [$];
	outcome_t            awaited [$];
	script_row_t         script [$];

	logic [TIME_W-1:0]   clock_ms = '0;
	bit                  quiet = 1'b0;
	bit                  hold_results = 1'b0;
	int unsigned         error_count = 0;
	int unsigned         sent = 0;
	int unsigned         due_seen = 0;
	int unsigned         created_seen = 0;
	int unsigned         full_seen = 0;
	int unsigned         cycle_count = 0;

	periodic_task_dispatcher dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.task_index (task_index),
		.freq_hz    (freq_hz),
		.start_now  (start_now),
		.now_ms     (now_ms),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.slot       (slot),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited", cycle_count,
				awaited.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [PERIOD_W-1:0] period_for(input logic [FREQ_W-1:0] f);
		if (f == '0)
			return '0;
		return PERIOD_W'(MS_PER_SECOND / f);
	endfunction

	// applies one request to the shadow table, leaves its results in step_out
	function automatic void dispatch_step(input request_t r);
		outcome_t          held;
		bit                have_held;
		logic [TIME_W-1:0] elapsed;
		step_out.delete();
		have_held = 1'b0;
		case (r.op)
			OP_TICK: begin
				for (int i = 0; i < TASKS; i++) begin
					if (i < created && started_mem[i]) begin
						elapsed = r.now - last_run_mem[i];
						if (elapsed >= period_mem[i]) begin
							last_run_mem[i] = r.now;
							if (have_held)
								step_out.push_back(held);
							held.kind = KIND_DUE;
							held.slot = SLOT_W'(i);
							held.last = 1'b0;
							have_held = 1'b1;
						end
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					step_out.push_back(held);
				end
			end
			OP_CREATE: begin
				if (created >= TASKS) begin
					held.kind = KIND_FULL;
					held.slot = '0;
				end else begin
					period_mem[created]   = period_for(r.freq);
					last_run_mem[created] = '0;
					started_mem[created]  = r.start;
					held.kind = KIND_CREATED;
					held.slot = SLOT_W'(created);
					created++;
				end
				held.last = 1'b1;
				step_out.push_back(held);
			end
			OP_START: begin
				if (r.idx < created)
					started_mem[r.idx] = 1'b1;
			end
			OP_STOP: begin
				if (r.idx < created)
					started_mem[r.idx] = 1'b0;
			end
			OP_SET_FREQ: begin
				if (r.idx < created)
					period_mem[r.idx] = period_for(r.freq);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		r.idx   = INDEX_W'($urandom_range(0, TASKS - 1));
		r.start = 1'($urandom_range(0, 1));
		r.now   = $urandom;
		case ($urandom_range(0, 3))
			0:       r.freq = '0;
			1:       r.freq = FREQ_W'($urandom_range(1, 8));
			2:       r.freq = FREQ_W'($urandom_range(1, 1000));
			default: r.freq = FREQ_W'($urandom);
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.op = OP_TICK;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				clock_ms = $urandom;
			else if (pick < 3)
				clock_ms += $urandom_range(900, 1100);
			else
				clock_ms += $urandom_range(0, 300);
			r.now = clock_ms;
		end else if (pick < 60) begin
			r.op = OP_SET_FREQ;
		end else if (pick < 75) begin
			r.op = OP_START;
		end else if (pick < 87) begin
			r.op = OP_STOP;
		end else if (pick < 92) begin
			r.op = OP_CREATE;
		end else begin
			r.op = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		return r;
	endfunction

	task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic [FREQ_W-1:0] freq, input logic start, input logic [TIME_W-1:0] now,
			input logic [4:0] reps, input logic typed, input kind_t k,
			input logic [SLOT_W-1:0] s);
		script_row_t row;
		row.req.op    = op;
		row.req.idx   = idx;
		row.req.freq  = freq;
		row.req.start = start;
		row.req.now   = now;
		row.reps      = reps;
		row.typed     = typed;
		row.kind      = k;
		row.slot      = s;
		script.push_back(row);
	endtask

	task automatic send_request(input request_t r, input logic typed, input kind_t k,
			input logic [SLOT_W-1:0] s);
		int unsigned gap;
		outcome_t    fixed;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		opcode     <= r.op;
		task_index <= r.idx;
		freq_hz    <= r.freq;
		start_now  <= r.start;
		now_ms     <= r.now;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		dispatch_step(r);
		if (typed) begin
			fixed.kind = k;
			fixed.slot = s;
			fixed.last = 1'b1;
			awaited.push_back(fixed);
		end else begin
			foreach (step_out[n])
				awaited.push_back(step_out[n]);
		end
		sent++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : watch_results
		outcome_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d slot %0d", kind, slot));
			end else begin
				want = awaited.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, awaited %0d", kind, want.kind));
				if (slot !== want.slot)
					report_mismatch($sformatf("slot %0d, awaited %0d", slot, want.slot));
				if (last !== want.last)
					report_mismatch($sformatf("last %0d, awaited %0d", last, want.last));
			end
			case (kind)
				KIND_DUE:     due_seen++;
				KIND_CREATED: created_seen++;
				default:      full_seen++;
			endcase
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin : result_side
		int unsigned n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				hold_results = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	initial begin : stimulus
		request_t    r;
		int unsigned useful;
		bit          pressed;
		useful  = 0;
		pressed = 1'b0;

		add_row(OP_TICK,        4'd0,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_START,       4'd0,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_STOP,        4'd15, 16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_SET_FREQ,    4'd3,  16'd500,   1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_SPARE_FIRST, 4'd0,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_SPARE_LAST,  4'd15, 16'hFFFF,  1'b1, 32'hFFFFFFFF,  1, 1'b0, KIND_DUE, 4'd0);
		// first creates after reset: slots come out in order
		add_row(OP_CREATE, 4'd0,  16'd0,    1'b1, 32'd0,        1, 1'b1, KIND_CREATED, 4'd0);
		add_row(OP_CREATE, 4'd0,  16'd1,    1'b1, 32'd0,        1, 1'b1, KIND_CREATED, 4'd1);
		add_row(OP_CREATE, 4'd0,  16'hFFFF, 1'b0, 32'd0,        1, 1'b1, KIND_CREATED, 4'd2);
		add_row(OP_CREATE, 4'd15, 16'd1000, 1'b1, 32'hFFFFFFFF, 1, 1'b1, KIND_CREATED, 4'd3);
		add_row(OP_CREATE, 4'd0,  16'd3,    1'b1, 32'd0,        1, 1'b1, KIND_CREATED, 4'd4);
		add_row(OP_TICK,        4'd0,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		// this tick runs at the top of the time range; elapsed time wraps past zero on the tick after it
		add_row(OP_TICK,        4'd0,  16'd0,     1'b0, 32'hFFFFFFFF,  1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_START,       4'd2,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_STOP,        4'd0,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_SET_FREQ,    4'd1,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_TICK,        4'd15, 16'hFFFF,  1'b1, 32'd5,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_START,       4'd7,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_CREATE,      4'd0,  16'd2,     1'b1, 32'd0,        11, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_CREATE, 4'd9,  16'd7,    1'b1, 32'd0,        1, 1'b1, KIND_FULL,    4'd0);
		add_row(OP_START,       4'd0,  16'd0,     1'b0, 32'd0,         1, 1'b0, KIND_DUE, 4'd0);
		add_row(OP_TICK,        4'd0,  16'd0,     1'b0, 32'h80000000,  1, 1'b0, KIND_DUE, 4'd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[n])
			repeat (script[n].reps)
				send_request(script[n].req, script[n].typed, script[n].kind, script[n].slot);
		clock_ms = 32'h80000000;

		while (useful < RANDOM_ITEMS) begin
			if (!pressed && useful >= PRESSURE_AT) begin
				// start every slot, then hold results while ticks keep coming
				for (int s = 0; s < TASKS; s++) begin
					r = random_request();
					r.op  = OP_START;
					r.idx = INDEX_W'(s);
					send_request(r, 1'b0, KIND_DUE, '0);
				end
				hold_results = 1'b1;
				repeat (6) begin
					r = random_request();
					r.op = OP_TICK;
					clock_ms += 1001;
					r.now = clock_ms;
					send_request(r, 1'b0, KIND_DUE, '0);
				end
				useful += TASKS + 6;
				pressed = 1'b1;
			end
			if (useful >= QUIET_FROM)
				quiet = 1'b1;
			r = random_request();
			send_request(r, 1'b0, KIND_DUE, '0);
			if (r.op < OP_SPARE_FIRST)
				useful++;
		end
		req_valid <= 1'b0;

		while (awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d requests; results seen: %0d due, %0d created, %0d table full",
			sent, due_seen, created_seen, full_seen);
		$display("the run included a long result hold-off and a final stretch with no idling");
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
